/* rtl/core/paddle_pot_line_emulator_core_assert.svh */
// Assertion macros for the checker module.
`ifndef PADDLE_POT_LINE_EMULATOR_CORE_ASSERT_SVH
`define PADDLE_POT_LINE_EMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define PPLE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pple: implication check failed");

// Next-cycle implication, off during reset.
`define PPLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pple: next-cycle check failed");

// Next-cycle implication, checked at every edge.
`define PPLE_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("pple: next-cycle check failed");

`endif

/* rtl/core/pple_pkg.sv */
package pple_pkg;

   localparam int POS_W     = 16;
   localparam int DELAY_W   = 6;
   localparam int COUNT_W   = 8;
   localparam int LINES     = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 1;

   localparam logic [10:0]        AXIS_LIMIT  = 11'd1024;
   localparam logic [DELAY_W-1:0] DELAY_RANGE = 6'd28;
   localparam logic [DELAY_W-1:0] BASE_A      = 6'd23;
   localparam logic [DELAY_W-1:0] BASE_B      = 6'd27;
   localparam logic [DELAY_W-1:0] MID_A       = 6'd37;
   localparam logic [DELAY_W-1:0] MID_B       = 6'd41;
   localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'hFF;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_A = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE_B = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COMBINED = 2'd2;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic en_rise;
      logic en_fall;
      logic update;
      logic tick;
      logic fall;
   } pple_port_ctl_type;

   // 28 - floor(v*28/1024) + base, v clamped to 1024
   function automatic logic [DELAY_W-1:0] axis_delay(input logic [POS_W-1:0] raw,
                                                     input logic [DELAY_W-1:0] base);
      logic [10:0] v;
      logic [14:0] prod;
      logic [4:0]  q;
      v    = (raw > POS_W'(AXIS_LIMIT)) ? AXIS_LIMIT : raw[10:0];
      prod = {v, 4'b0000} + {1'b0, v, 3'b000} + {2'b00, v, 2'b00};
      q    = prod[14:10];
      return DELAY_RANGE - {1'b0, q} + base;
   endfunction

endpackage

/* rtl/core/pple_if.sv */
interface pple_req_if import pple_pkg::*;;
   logic             valid;
   logic             ready;
   logic             cmd;
   logic [POS_W-1:0] pos_a_x;
   logic [POS_W-1:0] pos_a_y;
   logic [POS_W-1:0] pos_b_x;
   logic [POS_W-1:0] pos_b_y;
   logic             sense_a_fall;
   logic             sense_b_fall;

   modport source (output valid, cmd, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
                   sense_a_fall, sense_b_fall, input ready);
   modport sink   (input valid, cmd, pos_a_x, pos_a_y, pos_b_x, pos_b_y,
                   sense_a_fall, sense_b_fall, output ready);
endinterface

interface pple_rsp_if;
   logic valid;
   logic ready;
   logic drive_a;
   logic level_a_x;
   logic level_a_y;
   logic drive_b;
   logic level_b_x;
   logic level_b_y;

   modport source (output valid, drive_a, level_a_x, level_a_y, drive_b, level_b_x,
                   level_b_y, input ready);
   modport sink   (input valid, drive_a, level_a_x, level_a_y, drive_b, level_b_x,
                   level_b_y, output ready);
endinterface

interface pple_csr_if import pple_pkg::*;;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/paddle_pot_line_emulator_core.sv */
// An accepted req item reaches rsp through the input register and then the result register.
// Throughput: one item per cycle; the two-stage pipeline stalls only when rsp is not taken.
// Configuration writes take effect in the cycle after the write; csr is always ready.
// Reset (synchronous, active high) empties the pipeline, clears the valid, enable and mode
// registers, sets pending delays and compares to the port midpoints and stops both counters.
module paddle_pot_line_emulator_core import pple_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   pple_req_if.sink     req,
   pple_rsp_if.source   rsp,
   pple_csr_if.sink     csr
);

   logic             s1_valid_ff;
   logic             s1_cmd_ff;
   logic [POS_W-1:0] s1_ax_ff, s1_ay_ff, s1_bx_ff, s1_by_ff;
   logic             s1_fa_ff, s1_fb_ff;
   logic             s1_adv;
   logic             req_acc;

   logic             en_a_ff, en_b_ff, comb_ff;
   logic             csr_wr, csr_bit;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             drive_a_ff, drive_b_ff;
   logic [LINES-1:0] lvl_a_ff, lvl_b_ff;

   logic [POS_W-1:0]              ay_src, bx_src, by_src;
   logic [LINES-1:0][DELAY_W-1:0] dly_a, dly_b;
   pple_port_ctl_type             ctl_a, ctl_b;
   logic [LINES-1:0]              lvl_a_in, lvl_b_in;

   assign s1_adv    = s1_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !s1_valid_ff || s1_adv;
   assign req_acc   = req.valid && req.ready;
   assign csr.ready = 1'b1;
   assign csr_wr    = csr.valid && csr.ready;
   assign csr_bit   = csr.data[0];

   // combined mode: port A Y takes B X, port B positions forced to zero
   assign ay_src = comb_ff ? s1_bx_ff : s1_ay_ff;
   assign bx_src = comb_ff ? '0 : s1_bx_ff;
   assign by_src = comb_ff ? '0 : s1_by_ff;

   assign dly_a[0] = axis_delay(s1_ax_ff, BASE_A);
   assign dly_a[1] = axis_delay(ay_src, BASE_A);
   assign dly_b[0] = axis_delay(bx_src, BASE_B);
   assign dly_b[1] = axis_delay(by_src, BASE_B);

   always_comb begin
      ctl_a.en_rise = csr_wr && (csr.index == CSR_ENABLE_A) && csr_bit && !en_a_ff;
      ctl_a.en_fall = csr_wr && (csr.index == CSR_ENABLE_A) && !csr_bit && en_a_ff;
      ctl_a.update  = s1_adv && (s1_cmd_ff == CMD_UPDATE);
      ctl_a.tick    = s1_adv && (s1_cmd_ff == CMD_TICK) && en_a_ff;
      ctl_a.fall    = s1_fa_ff;
      ctl_b.en_rise = csr_wr && (csr.index == CSR_ENABLE_B) && csr_bit && !en_b_ff;
      ctl_b.en_fall = csr_wr && (csr.index == CSR_ENABLE_B) && !csr_bit && en_b_ff;
      ctl_b.update  = s1_adv && (s1_cmd_ff == CMD_UPDATE);
      ctl_b.tick    = s1_adv && (s1_cmd_ff == CMD_TICK) && en_b_ff;
      ctl_b.fall    = s1_fb_ff;
   end

   pple_port u_port_a (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_a),
      .mid       (MID_A),
      .upd_delay (dly_a),
      .level_in  (lvl_a_in)
   );

   pple_port u_port_b (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl_b),
      .mid       (MID_B),
      .upd_delay (dly_b),
      .level_in  (lvl_b_in)
   );

   always_comb begin
      if (s1_adv) rsp_valid_in = 1'b1;
      else if (rsp.ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         en_a_ff      <= 1'b0;
         en_b_ff      <= 1'b0;
         comb_ff      <= 1'b0;
      end else begin
         s1_valid_ff  <= req_acc || (s1_valid_ff && !s1_adv);
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            case (csr.index)
               CSR_ENABLE_A: en_a_ff <= csr_bit;
               CSR_ENABLE_B: en_b_ff <= csr_bit;
               CSR_COMBINED: comb_ff <= csr_bit;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_cmd_ff <= req.cmd;
         s1_ax_ff  <= req.pos_a_x;
         s1_ay_ff  <= req.pos_a_y;
         s1_bx_ff  <= req.pos_b_x;
         s1_by_ff  <= req.pos_b_y;
         s1_fa_ff  <= req.sense_a_fall;
         s1_fb_ff  <= req.sense_b_fall;
      end
      if (s1_adv) begin
         drive_a_ff <= en_a_ff;
         drive_b_ff <= en_b_ff;
         lvl_a_ff   <= en_a_ff ? lvl_a_in : '0;
         lvl_b_ff   <= en_b_ff ? lvl_b_in : '0;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.drive_a   = drive_a_ff;
   assign rsp.level_a_x = lvl_a_ff[0];
   assign rsp.level_a_y = lvl_a_ff[1];
   assign rsp.drive_b   = drive_b_ff;
   assign rsp.level_b_x = lvl_b_ff[0];
   assign rsp.level_b_y = lvl_b_ff[1];

endmodule

/* rtl/core/pple_port.sv */
module pple_port import pple_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  pple_port_ctl_type             ctl,
   input  logic [DELAY_W-1:0]            mid,
   input  logic [LINES-1:0][DELAY_W-1:0] upd_delay,
   output logic [LINES-1:0]              level_in
);

   logic [LINES-1:0][DELAY_W-1:0] pend_ff, pend_in;
   logic [LINES-1:0][DELAY_W-1:0] act_ff, act_in;
   logic [COUNT_W-1:0]            cnt_ff, cnt_in;
   logic                          run_ff, run_in;
   logic [LINES-1:0]              level_ff;

   always_comb begin
      pend_in  = pend_ff;
      act_in   = act_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      level_in = level_ff;
      if (ctl.en_rise) begin
         run_in   = 1'b0;
         act_in   = {LINES{mid}};
         level_in = '1;
      end else if (ctl.en_fall) begin
         run_in   = 1'b0;
         level_in = '0;
      end else if (ctl.update) begin
         pend_in = upd_delay;
      end else if (ctl.tick) begin
         if (ctl.fall) begin
            // restart timing, latch pending delays
            cnt_in   = '0;
            run_in   = 1'b1;
            level_in = '0;
            act_in   = pend_ff;
         end else if (run_ff) begin
            if (cnt_ff != COUNT_MAX) cnt_in = cnt_ff + COUNT_W'(1);
            for (int i = 0; i < LINES; i++) begin
               if (cnt_in == COUNT_W'(act_ff[i])) level_in[i] = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= {LINES{mid}};
         act_ff   <= {LINES{mid}};
         cnt_ff   <= '0;
         run_ff   <= 1'b0;
         level_ff <= '0;
      end else begin
         pend_ff  <= pend_in;
         act_ff   <= act_in;
         cnt_ff   <= cnt_in;
         run_ff   <= run_in;
         level_ff <= level_in;
      end
   end

endmodule

/* rtl/core/pple_checker.sv */
`include "paddle_pot_line_emulator_core_assert.svh"

module pple_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic drive_a,
   input logic level_a_x,
   input logic level_a_y,
   input logic drive_b,
   input logic level_b_x,
   input logic level_b_y
);

   logic       rsp_wait;
   logic [5:0] rsp_lines;

   assign rsp_wait  = rsp_valid && !rsp_ready;
   assign rsp_lines = {drive_a, level_a_x, level_a_y, drive_b, level_b_x, level_b_y};

   `PPLE_ASSERT_NEXT_ALWAYS(a_reset_empties, clock, reset, !rsp_valid)
   `PPLE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, rsp_valid && $stable(rsp_lines))
   `PPLE_ASSERT_IMPLY(a_released_a_low, clock, reset, rsp_valid && !drive_a, !level_a_x && !level_a_y)
   `PPLE_ASSERT_IMPLY(a_released_b_low, clock, reset, rsp_valid && !drive_b, !level_b_x && !level_b_y)

endmodule

bind paddle_pot_line_emulator_core pple_checker u_pple_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp.valid),
   .rsp_ready (rsp.ready),
   .drive_a   (rsp.drive_a),
   .level_a_x (rsp.level_a_x),
   .level_a_y (rsp.level_a_y),
   .drive_b   (rsp.drive_b),
   .level_b_x (rsp.level_b_x),
   .level_b_y (rsp.level_b_y)
);
